// ===== hdl/tes_pkg.sv =====
`default_nettype none
package tes_pkg;

  localparam int CoordWidth = 12;
  localparam int TagWidth   = 16;
  localparam int EdgeWidth  = 28;
  localparam int AreaWidth  = 62;
  localparam int QueueDepth = 2;

  // register indexes on the configuration port
  localparam logic CfgEdgeLimit = 1'b0;
  localparam logic CfgAreaLimit = 1'b1;

  // split case with every edge cut
  localparam logic [2:0] SubCaseAll = 3'd7;

  // rows 0..7 primary, 8..15 alternate diagonal; entry 0 is the piece count,
  // then three point indexes per piece (0..2 corners, 3..5 midpoints ab, bc, ca)
  localparam logic [2:0] SplitTbl [16][13] = '{
    '{3'd1, 3'd0,3'd1,3'd2, 3'd0,3'd0,3'd0, 3'd0,3'd0,3'd0, 3'd0,3'd0,3'd0},
    '{3'd2, 3'd0,3'd3,3'd2, 3'd3,3'd1,3'd2, 3'd0,3'd0,3'd0, 3'd0,3'd0,3'd0},
    '{3'd2, 3'd0,3'd1,3'd4, 3'd4,3'd2,3'd0, 3'd0,3'd0,3'd0, 3'd0,3'd0,3'd0},
    '{3'd3, 3'd3,3'd1,3'd4, 3'd3,3'd4,3'd2, 3'd2,3'd0,3'd3, 3'd0,3'd0,3'd0},
    '{3'd2, 3'd0,3'd1,3'd5, 3'd5,3'd1,3'd2, 3'd0,3'd0,3'd0, 3'd0,3'd0,3'd0},
    '{3'd3, 3'd0,3'd3,3'd5, 3'd5,3'd3,3'd1, 3'd1,3'd2,3'd5, 3'd0,3'd0,3'd0},
    '{3'd3, 3'd5,3'd4,3'd2, 3'd0,3'd1,3'd4, 3'd4,3'd5,3'd0, 3'd0,3'd0,3'd0},
    '{3'd4, 3'd0,3'd3,3'd5, 3'd3,3'd1,3'd4, 3'd5,3'd3,3'd4, 3'd5,3'd4,3'd2},
    '{3'd1, 3'd0,3'd1,3'd2, 3'd0,3'd0,3'd0, 3'd0,3'd0,3'd0, 3'd0,3'd0,3'd0},
    '{3'd2, 3'd0,3'd3,3'd2, 3'd3,3'd1,3'd2, 3'd0,3'd0,3'd0, 3'd0,3'd0,3'd0},
    '{3'd2, 3'd0,3'd1,3'd4, 3'd4,3'd2,3'd0, 3'd0,3'd0,3'd0, 3'd0,3'd0,3'd0},
    '{3'd3, 3'd3,3'd1,3'd4, 3'd0,3'd3,3'd4, 3'd4,3'd2,3'd0, 3'd0,3'd0,3'd0},
    '{3'd2, 3'd0,3'd1,3'd5, 3'd5,3'd1,3'd2, 3'd0,3'd0,3'd0, 3'd0,3'd0,3'd0},
    '{3'd3, 3'd0,3'd3,3'd5, 3'd3,3'd1,3'd2, 3'd2,3'd5,3'd3, 3'd0,3'd0,3'd0},
    '{3'd3, 3'd4,3'd2,3'd5, 3'd5,3'd0,3'd1, 3'd1,3'd4,3'd5, 3'd0,3'd0,3'd0},
    '{3'd4, 3'd0,3'd3,3'd5, 3'd3,3'd1,3'd4, 3'd5,3'd3,3'd4, 3'd5,3'd4,3'd2}
  };

  // queue occupancy seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } tes_qstat_t;

endpackage
`default_nettype wire

// ===== hdl/tes_if.sv =====
`default_nettype none
// input triangle channel
interface tes_tri_if #(
  parameter int CW = 12,
  parameter int TW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
  logic        [TW-1:0] source_tag;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  source_tag, input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  source_tag, output ready);
endinterface

// sub-triangle result channel
interface tes_sub_if #(
  parameter int CW = 12,
  parameter int TW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z;
  logic signed [CW-1:0] out_c_x, out_c_y, out_c_z;
  logic        [TW-1:0] out_tag;
  logic        [2:0]    split_case;
  logic                 last_piece;

  modport source (output valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y,
                  out_b_z, out_c_x, out_c_y, out_c_z, out_tag, split_case,
                  last_piece, input ready);
  modport sink   (input valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y,
                  out_b_z, out_c_x, out_c_y, out_c_z, out_tag, split_case,
                  last_piece, output ready);
endinterface
`default_nettype wire

// ===== hdl/tes_front.sv =====
`default_nettype none
module tes_front #(
  parameter int COORD_WIDTH = tes_pkg::CoordWidth,
  parameter int TAG_WIDTH   = tes_pkg::TagWidth,
  parameter int EW          = 18 * COORD_WIDTH + TAG_WIDTH + 4
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  tes_tri_if.sink                             tri_i,
  input  wire logic [tes_pkg::EdgeWidth-1:0]  edge_lim_i,
  input  wire logic [tes_pkg::AreaWidth-1:0]  area_lim_i,
  input  wire tes_pkg::tes_qstat_t            qstat_i,
  output logic                                push_o,
  output logic      [EW-1:0]                  entry_o
);
  import tes_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;       // coordinate difference
  localparam int PW = 2 * DW;       // product of two differences
  localparam int MW = PW + 1;       // cross product component
  localparam int NS = 8;            // pipeline depth

  logic en;
  logic [NS:1] v_q;

  // points and tag travel alongside every stage
  logic signed [CW-1:0] pts_q [1:NS][6][3];
  logic [TAG_WIDTH-1:0] tag_q [1:NS];
  logic [2:0]           sc_q  [5:NS];

  logic signed [DW-1:0] e1_q [3], e2_q [3], ed_q [3][3];
  logic signed [PW-1:0] prod_q [6];
  logic        [PW-1:0] esq_q [3][3];
  logic        [MW-1:0] mag_q [3];
  logic [2:0]           eo_q  [3:4];
  logic                 sat_q;
  logic [61:0]          sq_q [3];
  logic signed [DW-1:0] dd_q [2][3];
  logic        [PW-1:0] dsq_q [2][3];
  logic                 alt_q;

  logic signed [CW-1:0] vin [3][3];
  logic signed [MW-1:0] cr [3];
  logic [63:0]          magw [3];
  logic [63:0]          area2;
  logic [PW+1:0]        esum [3];
  logic [2:0]           dp [2][2];

  // the whole pipeline holds while its last stage waits on a full queue
  assign en          = !v_q[NS] || !qstat_i.full;
  assign tri_i.ready = en;
  assign push_o      = v_q[NS] && en;

  assign vin[0] = '{tri_i.a_x, tri_i.a_y, tri_i.a_z};
  assign vin[1] = '{tri_i.b_x, tri_i.b_y, tri_i.b_z};
  assign vin[2] = '{tri_i.c_x, tri_i.c_y, tri_i.c_z};

  always_comb begin
    // cross product from registered products
    cr[0] = MW'(prod_q[0]) - MW'(prod_q[1]);
    cr[1] = MW'(prod_q[2]) - MW'(prod_q[3]);
    cr[2] = MW'(prod_q[4]) - MW'(prod_q[5]);
    for (int i = 0; i < 3; i++) begin
      esum[i] = (PW+2)'(esq_q[i][0]) + (PW+2)'(esq_q[i][1]) + (PW+2)'(esq_q[i][2]);
      magw[i] = 64'(mag_q[i]);
    end
    area2 = 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
    // diagonal endpoints of the quad for the three-piece cases
    unique case (sc_q[5])
      3'd3:    dp = '{'{3'd3, 3'd2}, '{3'd4, 3'd0}};
      3'd5:    dp = '{'{3'd5, 3'd1}, '{3'd3, 3'd2}};
      3'd6:    dp = '{'{3'd0, 3'd4}, '{3'd1, 3'd5}};
      default: dp = '{'{3'd0, 3'd0}, '{3'd0, 3'd0}};
    endcase
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-1:1], tri_i.valid};
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1: corners, floored midpoints, differences
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          logic signed [DW-1:0] s;
          s = DW'(vin[i][k]) + DW'(vin[(i + 1) % 3][k]);
          pts_q[1][i][k]     <= vin[i][k];
          pts_q[1][3 + i][k] <= s[DW-1:1];
          ed_q[i][k]         <= DW'(vin[i][k]) - DW'(vin[(i + 1) % 3][k]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        e1_q[k] <= DW'(vin[1][k]) - DW'(vin[0][k]);
        e2_q[k] <= DW'(vin[2][k]) - DW'(vin[0][k]);
      end
      tag_q[1] <= tri_i.source_tag;

      // stage 2: products
      prod_q[0] <= e1_q[1] * e2_q[2];
      prod_q[1] <= e1_q[2] * e2_q[1];
      prod_q[2] <= e1_q[2] * e2_q[0];
      prod_q[3] <= e1_q[0] * e2_q[2];
      prod_q[4] <= e1_q[0] * e2_q[1];
      prod_q[5] <= e1_q[1] * e2_q[0];
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          esq_q[i][k] <= PW'(ed_q[i][k] * ed_q[i][k]);
        end
      end

      // stage 3: cross magnitudes and edge tests
      for (int i = 0; i < 3; i++) begin
        mag_q[i]  <= cr[i][MW-1] ? MW'(-cr[i]) : MW'(cr[i]);
        eo_q[3][i] <= 64'(esum[i]) > 64'(edge_lim_i);
      end

      // stage 4: squared magnitudes, saturation flag
      sat_q <= |magw[0][63:31] || |magw[1][63:31] || |magw[2][63:31];
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= magw[i][30:0] * magw[i][30:0];
      end
      eo_q[4] <= eo_q[3];

      // stage 5: split case
      sc_q[5] <= (sat_q || area2 > 64'(area_lim_i)) ? SubCaseAll : eo_q[4];

      // stage 6: diagonal differences
      for (int d = 0; d < 2; d++) begin
        for (int k = 0; k < 3; k++) begin
          dd_q[d][k] <= DW'(pts_q[5][dp[d][0]][k]) - DW'(pts_q[5][dp[d][1]][k]);
        end
      end

      // stage 7: diagonal squares
      for (int d = 0; d < 2; d++) begin
        for (int k = 0; k < 3; k++) begin
          dsq_q[d][k] <= PW'(dd_q[d][k] * dd_q[d][k]);
        end
      end

      // stage 8: diagonal choice, ties keep the primary row
      alt_q <= ((PW+2)'(dsq_q[0][0]) + (PW+2)'(dsq_q[0][1]) + (PW+2)'(dsq_q[0][2])) >
               ((PW+2)'(dsq_q[1][0]) + (PW+2)'(dsq_q[1][1]) + (PW+2)'(dsq_q[1][2]));

      for (int s = 2; s <= NS; s++) begin
        pts_q[s] <= pts_q[s-1];
        tag_q[s] <= tag_q[s-1];
      end
      for (int s = 6; s <= NS; s++) begin
        sc_q[s] <= sc_q[s-1];
      end
    end
  end

  // pack the queue entry
  always_comb begin
    entry_o = '0;
    for (int i = 0; i < 6; i++) begin
      for (int k = 0; k < 3; k++) begin
        entry_o[(i * 3 + k) * CW +: CW] = pts_q[NS][i][k];
      end
    end
    entry_o[18 * CW +: TAG_WIDTH] = tag_q[NS];
    entry_o[18 * CW + TAG_WIDTH +: 3] = sc_q[NS];
    entry_o[18 * CW + TAG_WIDTH + 3] =
      alt_q && (sc_q[NS] == 3'd3 || sc_q[NS] == 3'd5 || sc_q[NS] == 3'd6);
  end

endmodule
`default_nettype wire

// ===== hdl/tes_queue.sv =====
`default_nettype none
module tes_queue #(
  parameter int EW    = 8,
  parameter int DEPTH = tes_pkg::QueueDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic [EW-1:0]      data_i,
  input  wire logic               pop_i,
  output logic      [EW-1:0]      data_o,
  output tes_pkg::tes_qstat_t     stat_o
);
  import tes_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [EW-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign data_o       = mem_q[rd_q];
  assign stat_o.full  = cnt_q == (AW+1)'(DEPTH);
  assign stat_o.empty = cnt_q == '0;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tes_back.sv =====
`default_nettype none
module tes_back #(
  parameter int COORD_WIDTH = tes_pkg::CoordWidth,
  parameter int TAG_WIDTH   = tes_pkg::TagWidth,
  parameter int EW          = 18 * COORD_WIDTH + TAG_WIDTH + 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [EW-1:0]       entry_i,
  input  wire tes_pkg::tes_qstat_t qstat_i,
  output logic                     pop_o,
  tes_sub_if.source                sub_o
);
  import tes_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic [1:0]           piece_q;
  logic                 ov_q;
  logic                 load;
  logic [3:0]           row;
  logic [2:0]           cnt;
  logic                 last;
  logic signed [CW-1:0] vtx [3][3];

  assign row  = {entry_i[18 * CW + TAG_WIDTH + 3], entry_i[18 * CW + TAG_WIDTH +: 3]};
  assign cnt  = SplitTbl[row][0];
  assign last = (3'(piece_q) + 3'd1) == cnt;
  assign load = (!ov_q || sub_o.ready) && !qstat_i.empty;
  assign pop_o = load && last;
  assign sub_o.valid = ov_q;

  // pick the three points of the current piece
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      logic [2:0] idx;
      idx = SplitTbl[row][4'd1 + 4'(piece_q) * 4'd3 + 4'(v)];
      for (int k = 0; k < 3; k++) begin
        vtx[v][k] = entry_i[(int'(idx) * 3 + k) * CW +: CW];
      end
    end
  end

  // piece counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piece_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (load) begin
        piece_q <= last ? '0 : piece_q + 1'b1;
        ov_q    <= 1'b1;
      end else if (sub_o.ready) begin
        ov_q    <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      sub_o.out_a_x    <= vtx[0][0];
      sub_o.out_a_y    <= vtx[0][1];
      sub_o.out_a_z    <= vtx[0][2];
      sub_o.out_b_x    <= vtx[1][0];
      sub_o.out_b_y    <= vtx[1][1];
      sub_o.out_b_z    <= vtx[1][2];
      sub_o.out_c_x    <= vtx[2][0];
      sub_o.out_c_y    <= vtx[2][1];
      sub_o.out_c_z    <= vtx[2][2];
      sub_o.out_tag    <= entry_i[18 * CW +: TAG_WIDTH];
      sub_o.split_case <= row[2:0];
      sub_o.last_piece <= last;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/triangle_edge_split.sv =====
`default_nettype none
// Throughput: one sub-triangle per cycle while the sink is ready and the queue is
// not empty, 1 to 4 per triangle (piece count); one result port sets the rate.
// Front pipeline accepts one triangle per cycle while the 2-entry queue has room.
// Reset: asynchronous, active low; clears pipeline, queue and output valids,
// and sets both limit registers to all ones.
module triangle_edge_split #(
  parameter int COORD_WIDTH = tes_pkg::CoordWidth,
  parameter int TAG_WIDTH   = tes_pkg::TagWidth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  tes_tri_if.sink                            tri_i,
  tes_sub_if.source                          sub_o,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [tes_pkg::AreaWidth-1:0] cfg_data_i
);
  import tes_pkg::*;

  localparam int EW = 18 * COORD_WIDTH + TAG_WIDTH + 4;

  logic [EdgeWidth-1:0] edge_lim_q;
  logic [AreaWidth-1:0] area_lim_q;
  logic                 push, pop;
  logic [EW-1:0]        wr_entry, rd_entry;
  tes_qstat_t           qstat;

  // limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_lim_q <= '1;
      area_lim_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgEdgeLimit: edge_lim_q <= cfg_data_i[EdgeWidth-1:0];
        CfgAreaLimit: area_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tes_front #(.COORD_WIDTH(COORD_WIDTH), .TAG_WIDTH(TAG_WIDTH), .EW(EW)) u_front (
    .clk_i, .rst_ni, .tri_i,
    .edge_lim_i(edge_lim_q), .area_lim_i(area_lim_q),
    .qstat_i(qstat), .push_o(push), .entry_o(wr_entry)
  );

  tes_queue #(.EW(EW), .DEPTH(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(wr_entry),
    .pop_i(pop), .data_o(rd_entry), .stat_o(qstat)
  );

  tes_back #(.COORD_WIDTH(COORD_WIDTH), .TAG_WIDTH(TAG_WIDTH), .EW(EW)) u_back (
    .clk_i, .rst_ni, .entry_i(rd_entry), .qstat_i(qstat),
    .pop_o(pop), .sub_o
  );

  // queue never reports full and empty together
  a_qstat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty)) else $error("queue status inconsistent");

  // no push into a full queue
  a_nooverflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full) else $error("queue overflow");

  // an unsplit triangle is a single piece
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_o.valid && sub_o.split_case == 3'd0 |-> sub_o.last_piece)
    else $error("unsplit triangle not marked last");

endmodule
`default_nettype wire
